[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the tritan color simulation block.
// Depends on nothing; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is asserted.
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_SYNC(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/tcs_pkg.sv]
// Constants and helpers for the tritan color simulation block.
// Depends on nothing; imported by tritan_color_sim.
package tcs_pkg;

    localparam int        COEF_FRAC_BITS_DEF = 16;
    localparam longint    DEC_SCALE          = 100000000;
    localparam int        CHAN_W             = 8;
    localparam int        CHAN_MAX           = 255;

    // Coefficients in units of 1e-8.
    localparam longint SEL_SQLE_DEC [3] = '{999000, 6647390, 73170000};
    localparam longint SEL_SELQ_DEC [3] = '{15338400, 31662400, 5713400};

    localparam longint MAT_575_DEC [9] = '{
        42633100, 87510200, 8012710,
        28110000, 57119500, -3926270,
        -1770520, 2700840, 100247000
    };

    localparam longint MAT_475_DEC [9] = '{
        75810000, 145387000, -148060000,
        11853200, 28759500, 72550100,
        -746579, 4487110, 95430300
    };

    // Decimal coefficient to fixed point, rounded half away from zero.
    function automatic longint to_fixed(longint c, int frac);
        longint m;
        longint q;
        m = (c < 0) ? -c : c;
        q = ((m <<< frac) + DEC_SCALE / 2) / DEC_SCALE;
        return (c < 0) ? -q : q;
    endfunction

endpackage

[hw/rtl/tritan_color_sim.sv]
// Top level of the tritan color simulation block: a four stage pipeline.
// Depends on tcs_pkg and assert_macros.svh.
//
// Each beat carries one RGB color and yields exactly one simulated color one
// to one after four register stages, and the block takes one beat per
// cycle when the output side is ready. Stage one
// forms the two selector sums, stage two picks the half-plane, stage three
// multiplies the channels by the chosen matrix and stage four sums, rounds
// half up and saturates each channel into the output register. Each stage
// holds its beat while the stage after it is full and stalled.
`include "assert_macros.svh"

module tritan_color_sim
    import tcs_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // in_red [7:0], in_green [15:8], in_blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [0:0]  m_axis_tuser   // plane_used [0]
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = COEF_W + CHAN_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    typedef logic [CHAN_W-1:0]        t_chan;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    logic rdy1, rdy2, rdy3, rdy4;

    logic  r_v1, r_v2, r_v3, r_v4;
    t_chan r_ch1 [3];
    t_chan r_ch2 [3];
    t_acc  r_sqle, r_selq;
    logic  r_plane2, r_plane3, r_plane4;
    t_prod r_prod3 [9];
    t_chan r_out4 [3];

    t_acc  n_sqle, n_selq;
    t_prod n_prod [9];
    t_chan n_out [3];

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_comb begin
        t_prod c_sqle, c_selq, chv;
        n_sqle = '0;
        n_selq = '0;
        for (int k = 0; k < 3; k++) begin
            chv    = PROD_W'({1'b0, s_axis_tdata[k*CHAN_W +: CHAN_W]});
            c_sqle = PROD_W'(to_fixed(SEL_SQLE_DEC[k], COEF_FRAC_BITS));
            c_selq = PROD_W'(to_fixed(SEL_SELQ_DEC[k], COEF_FRAC_BITS));
            n_sqle = n_sqle + ACC_W'(c_sqle * chv);
            n_selq = n_selq + ACC_W'(c_selq * chv);
        end
    end

    always_comb begin
        t_prod coef, chv;
        for (int i = 0; i < 9; i++) begin
            if (r_plane2) begin
                coef = PROD_W'(to_fixed(MAT_475_DEC[i], COEF_FRAC_BITS));
            end else begin
                coef = PROD_W'(to_fixed(MAT_575_DEC[i], COEF_FRAC_BITS));
            end
            chv       = PROD_W'({1'b0, r_ch2[i%3]});
            n_prod[i] = coef * chv;
        end
    end

    always_comb begin
        t_acc sum;
        t_acc val;
        for (int r = 0; r < 3; r++) begin
            sum = ACC_W'(r_prod3[r*3]) + ACC_W'(r_prod3[r*3+1]) + ACC_W'(r_prod3[r*3+2])
                + (t_acc'(1) <<< (COEF_FRAC_BITS - 1));
            val = sum >>> COEF_FRAC_BITS;
            if (sum[ACC_W-1]) begin
                n_out[r] = '0;
            end else if (val > t_acc'(CHAN_MAX)) begin
                n_out[r] = t_chan'(CHAN_MAX);
            end else begin
                n_out[r] = val[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            for (int k = 0; k < 3; k++) begin
                r_ch1[k] <= s_axis_tdata[k*CHAN_W +: CHAN_W];
            end
            r_sqle <= n_sqle;
            r_selq <= n_selq;
        end
        if (rdy2 && r_v1) begin
            r_ch2    <= r_ch1;
            r_plane2 <= !(r_sqle < r_selq);
        end
        if (rdy3 && r_v2) begin
            r_prod3  <= n_prod;
            r_plane3 <= r_plane2;
        end
        if (rdy4 && r_v3) begin
            r_out4   <= n_out;
            r_plane4 <= r_plane3;
        end
    end

    assign m_axis_tvalid   = r_v4;
    assign m_axis_tdata    = {r_out4[2], r_out4[1], r_out4[0]};
    assign m_axis_tuser[0] = r_plane4;

    `ASSERT_SYNC(a_full_when_blocked, i_clk, i_rst_n,
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4))
    `ASSERT_SYNC(a_accept_fills_stage1, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
    `ASSERT_SYNC(a_plane_decision, i_clk, i_rst_n,
        (r_v1 && rdy2) |=> (r_v2 && (r_plane2 == $past(r_sqle >= r_selq))))
    `ASSERT_ALWAYS(a_empty_after_reset, i_clk,
        !i_rst_n |=> !m_axis_tvalid)

endmodule
